// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CHK_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ssl_pkg.sv =====
package ssl_pkg;

  localparam int KEY_W   = 32;
  localparam int LEVEL_W = 7;

  localparam logic [63:0] MURMUR_M  = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MURMUR_8M = MURMUR_M << 3;
  localparam logic [63:0] MM3_C1    = 64'h87c37b91114253d5;
  localparam logic [63:0] MM3_C2    = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_K1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_K2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM3_LEN   = 64'd12;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SEED    = 2'd0,
    REG_BUCKETS = 2'd1,
    REG_BITS    = 2'd2,
    REG_NONE    = 2'd3
  } reg_t;

  // Hash datapath micro-operations.
  typedef enum logic [4:0] {
    MOP_NOP, MOP_LD_EDGE, MOP_LD_K2, MOP_LD_K1,
    MOP_MUL0, MOP_MUL1, MOP_MUL2,
    MOP_XSH47, MOP_XSH47_P, MOP_XSH33, MOP_ROTL33, MOP_ROTL31,
    MOP_XOR_SEED64, MOP_SAVE_H2, MOP_XOR_S32, MOP_ADD_W, MOP_ADD_H, MOP_SWAP
  } mop_t;

  typedef enum logic [2:0] {
    K_M, K_C1, K_C2, K_F1, K_F2
  } ksel_t;

  typedef struct packed {
    mop_t  mop;
    ksel_t ksel;
  } ucode_t;

  localparam logic [5:0] HASH_MM3_START = 6'd17;
  localparam logic [5:0] HASH_LAST      = 6'd57;

  typedef struct packed {
    mop_t       mop;
    ksel_t      ksel;
    logic       load_in;
    logic       lvlpos;
    logic       addr_load;
    logic [1:0] row;
    logic       rd;
    logic       modify;
    logic       cnt_step;
    logic       emit;
    logic       clr_step;
  } ssl_cmd_t;

  typedef struct packed {
    op_t  in_op;
    op_t  op;
    logic clr_last;
    logic cnt_last;
    logic bkt_ok;
    logic out_busy;
  } ssl_sts_t;

  function automatic logic [63:0] kconst(input ksel_t k);
    logic [63:0] v;
    unique case (k)
      K_M:     v = MURMUR_M;
      K_C1:    v = MM3_C1;
      K_C2:    v = MM3_C2;
      K_F1:    v = FMIX_K1;
      K_F2:    v = FMIX_K2;
      default: v = MURMUR_M;
    endcase
    return v;
  endfunction

  // Steps 0..16: 64-bit edge hash. Steps 17..57: 128-bit key hash.
  function automatic ucode_t ucode(input logic [5:0] step);
    ucode_t u;
    u.ksel = K_M;
    unique case (step)
      6'd0:                       u.mop = MOP_LD_EDGE;
      6'd1, 6'd5, 6'd9, 6'd13:    u.mop = MOP_MUL0;
      6'd2, 6'd6, 6'd10, 6'd14:   u.mop = MOP_MUL1;
      6'd3, 6'd7, 6'd11, 6'd15:   u.mop = MOP_MUL2;
      6'd4, 6'd12:                u.mop = MOP_XSH47;
      6'd8:                       u.mop = MOP_XOR_SEED64;
      6'd16:                      u.mop = MOP_XSH47_P;
      6'd17:                      u.mop = MOP_LD_K2;
      6'd18: begin u.mop = MOP_MUL0; u.ksel = K_C2; end
      6'd19: begin u.mop = MOP_MUL1; u.ksel = K_C2; end
      6'd20: begin u.mop = MOP_MUL2; u.ksel = K_C2; end
      6'd21:                      u.mop = MOP_ROTL33;
      6'd22: begin u.mop = MOP_MUL0; u.ksel = K_C1; end
      6'd23: begin u.mop = MOP_MUL1; u.ksel = K_C1; end
      6'd24: begin u.mop = MOP_MUL2; u.ksel = K_C1; end
      6'd25:                      u.mop = MOP_SAVE_H2;
      6'd26:                      u.mop = MOP_LD_K1;
      6'd27: begin u.mop = MOP_MUL0; u.ksel = K_C1; end
      6'd28: begin u.mop = MOP_MUL1; u.ksel = K_C1; end
      6'd29: begin u.mop = MOP_MUL2; u.ksel = K_C1; end
      6'd30:                      u.mop = MOP_ROTL31;
      6'd31: begin u.mop = MOP_MUL0; u.ksel = K_C2; end
      6'd32: begin u.mop = MOP_MUL1; u.ksel = K_C2; end
      6'd33: begin u.mop = MOP_MUL2; u.ksel = K_C2; end
      6'd34:                      u.mop = MOP_XOR_S32;
      6'd35, 6'd57:               u.mop = MOP_ADD_W;
      6'd36, 6'd56:               u.mop = MOP_ADD_H;
      6'd37, 6'd41, 6'd45, 6'd47, 6'd51, 6'd55: u.mop = MOP_XSH33;
      6'd38, 6'd48: begin u.mop = MOP_MUL0; u.ksel = K_F1; end
      6'd39, 6'd49: begin u.mop = MOP_MUL1; u.ksel = K_F1; end
      6'd40, 6'd50: begin u.mop = MOP_MUL2; u.ksel = K_F1; end
      6'd42, 6'd52: begin u.mop = MOP_MUL0; u.ksel = K_F2; end
      6'd43, 6'd53: begin u.mop = MOP_MUL1; u.ksel = K_F2; end
      6'd44, 6'd54: begin u.mop = MOP_MUL2; u.ksel = K_F2; end
      6'd46:                      u.mop = MOP_SWAP;
      default:                    u.mop = MOP_NOP;
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/ssl_ram.sv =====
module ssl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic                             re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                     rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ssl_ctrl.sv =====
module ssl_ctrl
  import ssl_pkg::*;
#(
  parameter int ROWS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output ssl_cmd_t cmd,
  input  ssl_sts_t sts
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_LVL   = 9'b000001000,
    S_ADDR  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_MOD   = 9'b001000000,
    S_COUNT = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic [1:0] row_r, row_nxt;

  always_comb begin
    ucode_t u;
    u         = ucode(step_r);
    cmd       = '0;
    cmd.mop   = MOP_NOP;
    cmd.ksel  = K_M;
    cmd.row   = row_r;
    state_nxt = state_r;
    step_nxt  = step_r;
    row_nxt   = row_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          row_nxt     = 2'd0;
          unique case (sts.in_op)
            OP_UPDATE: begin
              step_nxt  = 6'd0;
              state_nxt = S_HASH;
            end
            OP_QUERY: begin
              step_nxt  = HASH_MM3_START;
              state_nxt = S_HASH;
            end
            OP_READ:  state_nxt = S_ADDR;
            OP_NONE:  state_nxt = S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH: begin
        cmd.mop  = u.mop;
        cmd.ksel = u.ksel;
        step_nxt = 6'(step_r + 6'd1);
        if (step_r == HASH_LAST) begin
          state_nxt = (sts.op == OP_UPDATE) ? S_LVL : S_ADDR;
        end
      end
      S_LVL: begin
        cmd.lvlpos = 1'b1;
        state_nxt  = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt = (sts.op == OP_READ && !sts.bkt_ok) ? S_COUNT : S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.modify = 1'b1;
        if (sts.op == OP_READ) begin
          state_nxt = S_COUNT;
        end else if (row_r == 2'(ROWS - 1)) begin
          state_nxt = (sts.op == OP_UPDATE) ? S_IDLE : S_COUNT;
        end else begin
          row_nxt   = 2'(row_r + 2'd1);
          state_nxt = S_ADDR;
        end
      end
      S_COUNT: begin
        cmd.cnt_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= 6'd0;
      row_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

// ===== rtl/core/ssl_dp.sv =====
module ssl_dp
  import ssl_pkg::*;
#(
  parameter int ROWS            = 4,
  parameter int MAX_BUCKETS     = 512,
  parameter int MAX_BITMAP_BITS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ssl_cmd_t    cmd,
  output ssl_sts_t    sts,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata
);

  localparam int ENTRIES = ROWS * MAX_BUCKETS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW      = $clog2(MAX_BITMAP_BITS);
  localparam int NCH     = (MAX_BITMAP_BITS + 31) / 32;
  localparam int CHW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ACCW    = NCH * 32;
  localparam int CW      = $clog2(ACCW + 1);
  localparam int XW      = (CW > 9) ? CW : 9;
  localparam int DW      = MAX_BITMAP_BITS + KEY_W + LEVEL_W;

  // Configuration.
  logic [63:0] seed_r;
  logic [9:0]  bucket_count_r;
  logic [8:0]  bitmap_bits_r;
  logic [9:0]  effb;
  logic [8:0]  effbits;

  // Captured item.
  op_t         op_r;
  logic [31:0] src_r, dst_r;
  logic [1:0]  rrow_r;
  logic [8:0]  rbkt_r;

  // Hash unit.
  logic [63:0] w_r, h_r, p_r, macc_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, kval;

  logic [LEVEL_W-1:0] lvl_r;
  logic [PW-1:0]      pos_r;
  logic [40:0]        pprod;

  // Bucket addressing and memory.
  logic [31:0] word;
  logic [41:0] bprod;
  logic [AW:0] addr_sum;
  logic [1:0]  arow;
  logic [9:0]  abkt;
  logic [AW-1:0] addr_r, clr_cnt_r, waddr;
  logic          we;
  logic [DW-1:0] wdata, rdata;
  logic [MAX_BITMAP_BITS-1:0] old_bm, new_bm;
  logic [KEY_W-1:0]           old_key;
  logic [LEVEL_W-1:0]         old_lvl;
  logic                       bkt_ok;

  // Counting.
  logic [ACCW-1:0] acc_r;
  logic [CHW-1:0]  chunk_r;
  logic [CW-1:0]   cnt_r;
  logic [5:0]      pc;
  logic [XW-1:0]   cnt_x, m_x;
  logic [8:0]      zc;
  logic [KEY_W-1:0]   okey_r;
  logic [LEVEL_W-1:0] olvl_r;

  logic        out_valid_r;
  logic [47:0] out_data_r;

  function automatic logic [LEVEL_W-1:0] trail_ones(input logic [63:0] v);
    logic [3:0]         t [8];
    logic [7:0]         full;
    logic [7:0]         b;
    logic               run;
    logic [LEVEL_W-1:0] tot;
    for (int k = 0; k < 8; k++) begin
      b    = v[8*k +: 8];
      t[k] = 4'd0;
      run  = 1'b1;
      for (int j = 0; j < 8; j++) begin
        if (run && b[j]) t[k] = 4'(t[k] + 4'd1);
        else run = 1'b0;
      end
      full[k] = &b;
    end
    tot = '0;
    run = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (run) begin
        tot = LEVEL_W'(tot + LEVEL_W'(t[k]));
        if (!full[k]) run = 1'b0;
      end
    end
    return LEVEL_W'(tot + LEVEL_W'(1));
  endfunction

  assign effb    = (int'(bucket_count_r) > MAX_BUCKETS) ? 10'(MAX_BUCKETS) : bucket_count_r;
  assign effbits = (bitmap_bits_r == 9'd0) ? 9'd1 :
                   (int'(bitmap_bits_r) > MAX_BITMAP_BITS) ? 9'(MAX_BITMAP_BITS)
                                                           : bitmap_bits_r;

  // One shared 32x32 multiplier builds each 64-bit product in three steps.
  assign kval  = kconst(cmd.ksel);
  assign mul_a = (cmd.mop == MOP_MUL2) ? w_r[63:32] : w_r[31:0];
  assign mul_b = (cmd.mop == MOP_MUL1) ? kval[63:32] : kval[31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign pprod = {9'd0, p_r[63:32]} * {32'd0, effbits};

  always_comb begin
    unique case (cmd.row)
      2'd0:    word = h_r[31:0];
      2'd1:    word = h_r[63:32];
      2'd2:    word = w_r[31:0];
      default: word = w_r[63:32];
    endcase
  end

  assign bprod    = {10'd0, word} * {32'd0, effb};
  assign bkt_ok   = (int'(rrow_r) < ROWS) && (int'(rbkt_r) < MAX_BUCKETS);
  assign arow     = (op_r == OP_READ) ? rrow_r : cmd.row;
  assign abkt     = (op_r == OP_READ) ? {1'b0, rbkt_r} : bprod[41:32];
  assign addr_sum = (AW+1)'(arow) * (AW+1)'(MAX_BUCKETS) + (AW+1)'(abkt);

  assign old_bm  = rdata[MAX_BITMAP_BITS-1:0];
  assign old_key = rdata[MAX_BITMAP_BITS +: KEY_W];
  assign old_lvl = rdata[MAX_BITMAP_BITS + KEY_W +: LEVEL_W];
  assign new_bm  = old_bm | ({{(MAX_BITMAP_BITS-1){1'b0}}, 1'b1} << pos_r);

  always_comb begin
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      we    = cmd.modify && (op_r == OP_UPDATE);
      waddr = addr_r;
      if (old_lvl < lvl_r) wdata = {lvl_r, src_r, new_bm};
      else                 wdata = {old_lvl, old_key, new_bm};
    end
  end

  ssl_ram #(
    .W(DW),
    .D(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(addr_r),
    .rdata(rdata)
  );

  // Masked popcount of the low chunk.
  always_comb begin
    pc = 6'd0;
    for (int j = 0; j < 32; j++) begin
      if (acc_r[j] && ((int'(chunk_r) * 32 + j) < int'(effbits))) pc = 6'(pc + 6'd1);
    end
  end

  assign cnt_x = XW'(cnt_r);
  assign m_x   = XW'(effbits);
  assign zc    = (cnt_x >= m_x) ? 9'd1 : 9'(m_x - cnt_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r         <= 64'd0;
      bucket_count_r <= 10'd512;
      bitmap_bits_r  <= 9'd256;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      op_r           <= OP_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_t'(cfg_index))
          REG_SEED:    seed_r         <= cfg_data;
          REG_BUCKETS: bucket_count_r <= cfg_data[9:0];
          REG_BITS:    bitmap_bits_r  <= cfg_data[8:0];
          default:     ;
        endcase
      end
      if (cmd.clr_step) clr_cnt_r <= AW'(clr_cnt_r + AW'(1));
      if (cmd.load_in) op_r <= op_t'(in_tuser);
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      src_r   <= in_tdata[31:0];
      dst_r   <= in_tdata[63:32];
      rrow_r  <= in_tdata[65:64];
      rbkt_r  <= in_tdata[74:66];
      acc_r   <= '1;
      chunk_r <= '0;
      cnt_r   <= '0;
      okey_r  <= '0;
      olvl_r  <= '0;
    end
    unique case (cmd.mop)
      MOP_NOP:        ;
      MOP_LD_EDGE:    w_r <= {src_r, dst_r};
      MOP_LD_K2:      w_r <= {32'd0, src_r};
      MOP_LD_K1:      w_r <= {src_r, src_r};
      MOP_MUL0:       macc_r <= mul_p;
      MOP_MUL1:       macc_r <= macc_r + {mul_p[31:0], 32'd0};
      MOP_MUL2:       w_r <= macc_r + {mul_p[31:0], 32'd0};
      MOP_XSH47:      w_r <= w_r ^ (w_r >> 47);
      MOP_XSH47_P:    p_r <= w_r ^ (w_r >> 47);
      MOP_XSH33:      w_r <= w_r ^ (w_r >> 33);
      MOP_ROTL33:     w_r <= {w_r[30:0], w_r[63:31]};
      MOP_ROTL31:     w_r <= {w_r[32:0], w_r[63:33]};
      MOP_XOR_SEED64: w_r <= w_r ^ seed_r ^ MURMUR_8M;
      MOP_SAVE_H2:    h_r <= w_r ^ {32'd0, seed_r[31:0]} ^ MM3_LEN;
      MOP_XOR_S32:    w_r <= w_r ^ {32'd0, seed_r[31:0]} ^ MM3_LEN;
      MOP_ADD_W:      w_r <= w_r + h_r;
      MOP_ADD_H:      h_r <= h_r + w_r;
      MOP_SWAP: begin
        w_r <= h_r;
        h_r <= w_r;
      end
      default:        ;
    endcase
    if (cmd.lvlpos) begin
      lvl_r <= trail_ones(p_r);
      pos_r <= PW'(pprod[40:32]);
    end
    if (cmd.addr_load) begin
      addr_r <= addr_sum[AW-1:0];
      if (op_r == OP_READ && !bkt_ok) acc_r <= '0;
    end
    if (cmd.modify) begin
      if (op_r == OP_READ) begin
        acc_r  <= ACCW'(old_bm);
        okey_r <= old_key;
        olvl_r <= old_lvl;
      end else if (op_r == OP_QUERY) begin
        acc_r <= acc_r & ACCW'(old_bm);
      end
    end
    if (cmd.cnt_step) begin
      cnt_r   <= CW'(cnt_r + CW'(pc));
      acc_r   <= acc_r >> 32;
      chunk_r <= CHW'(chunk_r + CHW'(1));
    end
    if (cmd.emit) out_data_r <= {olvl_r, okey_r, zc};
  end

  assign sts.in_op    = op_t'(in_tuser);
  assign sts.op       = op_r;
  assign sts.clr_last = (clr_cnt_r == AW'(ENTRIES - 1));
  assign sts.cnt_last = (chunk_r == CHW'(NCH - 1));
  assign sts.bkt_ok   = bkt_ok;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/spread_sketch_linear_counting.sv =====
// Update: accept, hash steps, level step, then address, read, modify per row. Point
// query: key hash steps, the per-row accesses, a count over the bitmap in 32-bit
// chunks, result. Bucket read: accept, address, read if the bucket is valid, count,
// result. Rate is set by the shared 32x32 hash multiplier (three steps per 64-bit
// product) and the bucket read-modify-write. Synchronous active-low reset; then a
// clearing pass zeroes all ROWS*MAX_BUCKETS entries, one per cycle, input held off.
module spread_sketch_linear_counting
  import ssl_pkg::*;
#(
  parameter int ROWS            = 4,
  parameter int MAX_BUCKETS     = 512,
  parameter int MAX_BITMAP_BITS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // src_key[31:0], dst_key[63:32], row_index[65:64],
                                  // bucket_index[74:66], zero pad [79:75]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // zero_count[8:0], stored_key[40:9], stored_level[47:41]
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ssl_cmd_t cmd;
  ssl_sts_t sts;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: clearing pass, hash micro-steps, per-row bucket access, count.
  ssl_ctrl #(
    .ROWS(ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hash unit, bucket memory, bitmap counter and the output register.
  ssl_dp #(
    .ROWS           (ROWS),
    .MAX_BUCKETS    (MAX_BUCKETS),
    .MAX_BITMAP_BITS(MAX_BITMAP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ===== rtl/core/ssl_checker.sv =====
`include "assert_macros.svh"

module ssl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  `CHK_ON(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CHK_ON(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled result changed")
  `CHK_ON(a_zero_min, out_tvalid |-> out_tdata[8:0] != 9'd0, "zero count below one")
  `CHK_ALWAYS(a_rst_quiet, !rst_n |=> !in_tready && !out_tvalid, "active right after reset")

endmodule

bind spread_sketch_linear_counting ssl_checker u_chk (.*);
